>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL: same-cycle and next-cycle checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CCS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ccs_pkg.sv
// ---------------------------------------------------------------------------
// ccs_pkg
// Types, widths and reset constants of the colour sorter controller.
// ---------------------------------------------------------------------------
package ccs_pkg;

  localparam int unsigned TicksW  = 26;
  localparam int unsigned MarginW = 16;
  localparam int unsigned AngleW  = 8;
  localparam int unsigned WidthW  = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 26;

  localparam logic [TicksW-1:0]  TicksRst  = TicksW'(2000000);
  localparam logic [MarginW-1:0] MarginRst = MarginW'(15);
  localparam logic [AngleW-1:0]  AngleRst  = AngleW'(45);
  localparam logic [AngleW-1:0]  AngleMax  = AngleW'(180);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ANALYSIS_TICKS = 2'd0,
    CFG_MARGIN         = 2'd1,
    CFG_PUSH_ANGLE     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_STOPPED   = 2'd0,
    MODE_ADVANCING = 2'd1,
    MODE_ANALYSING = 2'd2,
    MODE_WAITING   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_BLUE  = 2'd1,
    CLASS_GREEN = 2'd2,
    CLASS_RED   = 2'd3
  } class_e;

  typedef struct packed {
    logic              start_button;
    logic              stop_button;
    logic              beam_clear;
    logic [WidthW-1:0] red_width;
    logic [WidthW-1:0] green_width;
    logic [WidthW-1:0] blue_width;
  } item_t;

  typedef struct packed {
    logic [TicksW-1:0]  analysis_ticks;
    logic [MarginW-1:0] margin;
    logic [AngleW-1:0]  push_angle;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    logic [TicksW-1:0] dwell;
    logic              motor;
    logic              lamp_red;
    logic              lamp_green;
    logic              lamp_blue;
    logic [AngleW-1:0] blue_angle;
    logic [AngleW-1:0] green_angle;
    class_e            cls;
  } state_t;

endpackage

>>> rtl/ccs_in_if.sv
// ---------------------------------------------------------------------------
// ccs_in_if
// Tick channel: buttons, beam sensor and colour pulse widths.
// ---------------------------------------------------------------------------
interface ccs_in_if;
  import ccs_pkg::*;

  logic              valid;
  logic              ready;
  logic              start_button;
  logic              stop_button;
  logic              beam_clear;
  logic [WidthW-1:0] red_width;
  logic [WidthW-1:0] green_width;
  logic [WidthW-1:0] blue_width;

  modport source (
    output valid, start_button, stop_button, beam_clear,
           red_width, green_width, blue_width,
    input  ready
  );

  modport sink (
    input  valid, start_button, stop_button, beam_clear,
           red_width, green_width, blue_width,
    output ready
  );
endinterface

>>> rtl/ccs_out_if.sv
// ---------------------------------------------------------------------------
// ccs_out_if
// Result channel: phase, motor, lamp, diverter angles and colour class.
// ---------------------------------------------------------------------------
interface ccs_out_if;
  import ccs_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        phase;
  logic              motor_run;
  logic              lamp_red;
  logic              lamp_green;
  logic              lamp_blue;
  logic [AngleW-1:0] blue_servo_angle;
  logic [AngleW-1:0] green_servo_angle;
  logic [1:0]        color_class;

  modport source (
    output valid, phase, motor_run, lamp_red, lamp_green, lamp_blue,
           blue_servo_angle, green_servo_angle, color_class,
    input  ready
  );

  modport sink (
    input  valid, phase, motor_run, lamp_red, lamp_green, lamp_blue,
           blue_servo_angle, green_servo_angle, color_class,
    output ready
  );
endinterface

>>> rtl/conveyor_color_sorter_controller_top.sv
// ---------------------------------------------------------------------------
// conveyor_color_sorter_controller_top
// Conveyor colour sorter: phase sequencer, colour decision and drive state.
// ---------------------------------------------------------------------------
// Usage
// - in_if (sink): one beat per time-base tick, carrying start/stop buttons,
//   the beam sensor level and the red, green and blue pulse widths.
// - out_if (source): one beat per tick, the controller state after that
//   tick: phase, motor, lamp channels, diverter angles and colour class.
// - cfg_*: write-only registers (analysis ticks, margin, push angle),
//   written on any clock edge with cfg_we_i high; change them only while
//   no tick is in flight.
// Timing
// - Tick beat is captured in an input register; the step logic then updates
//   the state register, which is also the result register.
// - Throughput is one tick per cycle while the result side keeps taking results.
// Reset (rst_ni low, asynchronous): phase stopped, motor and lamp off,
//   angles 0, class undetermined, registers back to their defaults.
// Stall: while the result is not taken the state holds; one more tick may
//   wait in the input register, after which in_if.ready drops.
// ---------------------------------------------------------------------------
module conveyor_color_sorter_controller_top import ccs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ccs_in_if.sink             in_if,
  ccs_out_if.source          out_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  // configuration registers
  cfg_t   cfg_q;

  // input stage
  logic   in_valid_q;
  item_t  item_q;

  // state doubles as result register
  logic   out_valid_q;
  state_t state_q, state_d;

  logic   advance;

  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.analysis_ticks <= TicksRst;
      cfg_q.margin         <= MarginRst;
      cfg_q.push_angle     <= AngleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANALYSIS_TICKS: cfg_q.analysis_ticks <= cfg_wdata_i[TicksW-1:0];
        CFG_MARGIN:         cfg_q.margin         <= cfg_wdata_i[MarginW-1:0];
        CFG_PUSH_ANGLE:     cfg_q.push_angle     <= cfg_wdata_i[AngleW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register: payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q.start_button <= in_if.start_button;
      item_q.stop_button  <= in_if.stop_button;
      item_q.beam_clear   <= in_if.beam_clear;
      item_q.red_width    <= in_if.red_width;
      item_q.green_width  <= in_if.green_width;
      item_q.blue_width   <= in_if.blue_width;
    end
  end

  ccs_step u_step (
    .cur_i  (state_q),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .nxt_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q         <= 1'b0;
      state_q.mode        <= MODE_STOPPED;
      state_q.dwell       <= '0;
      state_q.motor       <= 1'b0;
      state_q.lamp_red    <= 1'b0;
      state_q.lamp_green  <= 1'b0;
      state_q.lamp_blue   <= 1'b0;
      state_q.blue_angle  <= '0;
      state_q.green_angle <= '0;
      state_q.cls         <= CLASS_NONE;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.phase             = state_q.mode;
  assign out_if.motor_run         = state_q.motor;
  assign out_if.lamp_red          = state_q.lamp_red;
  assign out_if.lamp_green        = state_q.lamp_green;
  assign out_if.lamp_blue         = state_q.lamp_blue;
  assign out_if.blue_servo_angle  = state_q.blue_angle;
  assign out_if.green_servo_angle = state_q.green_angle;
  assign out_if.color_class       = state_q.cls;

  // ---- assertions ----
`include "assert_macros.svh"

  // belt is halted for the whole analysis dwell
  `CCS_ASSERT(a_no_motor_analysing, state_q.mode == MODE_ANALYSING, !state_q.motor,
              "motor running while analysing")

  // stopped means everything off
  `CCS_ASSERT(a_stopped_quiet, state_q.mode == MODE_STOPPED,
              !state_q.motor && !state_q.lamp_red && !state_q.lamp_green &&
              !state_q.lamp_blue && state_q.blue_angle == '0 && state_q.green_angle == '0,
              "drive active while stopped")

  // dwell counter only live in the analysing phase
  `CCS_ASSERT(a_dwell_idle, state_q.mode != MODE_ANALYSING, state_q.dwell == '0,
              "dwell count outside analysis")

  // state moves only when a tick passes into the result register
  `CCS_ASSERT_NEXT(a_state_hold, !advance, $stable(state_q),
                   "state changed without a tick")

endmodule

>>> rtl/ccs_step.sv
// ---------------------------------------------------------------------------
// ccs_step
// Next-state logic for one tick: stop/start, phase sequence, classification.
// ---------------------------------------------------------------------------
module ccs_step import ccs_pkg::*; (
  input  state_t cur_i,
  input  item_t  item_i,
  input  cfg_t   cfg_i,
  output state_t nxt_o
);

  logic [WidthW:0]   r_ext, g_ext, b_ext;
  logic [WidthW:0]   r_sum, g_sum, b_sum;
  logic              pick_blue, pick_green, pick_red;
  logic [AngleW-1:0] angle_sat;
  logic [TicksW-1:0] limit;
  logic [TicksW-1:0] dwell_inc;

  // pulse + margin compared against the others; one extra bit avoids wrap
  assign r_ext = {1'b0, item_i.red_width};
  assign g_ext = {1'b0, item_i.green_width};
  assign b_ext = {1'b0, item_i.blue_width};
  assign r_sum = r_ext + (WidthW+1)'(cfg_i.margin);
  assign g_sum = g_ext + (WidthW+1)'(cfg_i.margin);
  assign b_sum = b_ext + (WidthW+1)'(cfg_i.margin);

  assign pick_blue  = (b_sum < r_ext) && (b_sum < g_ext);
  assign pick_green = (g_sum < r_ext) && (g_sum < b_ext);
  assign pick_red   = (r_sum < g_ext) && (r_sum < b_ext);

  assign angle_sat = (cfg_i.push_angle > AngleMax) ? AngleMax : cfg_i.push_angle;
  assign limit     = (cfg_i.analysis_ticks == '0) ? TicksW'(1) : cfg_i.analysis_ticks;

  always_comb begin
    nxt_o     = cur_i;
    dwell_inc = '0;

    if (item_i.stop_button && (cur_i.mode != MODE_STOPPED)) begin
      nxt_o.motor       = 1'b0;
      nxt_o.lamp_red    = 1'b0;
      nxt_o.lamp_green  = 1'b0;
      nxt_o.lamp_blue   = 1'b0;
      nxt_o.blue_angle  = '0;
      nxt_o.green_angle = '0;
      nxt_o.dwell       = '0;
      nxt_o.mode        = MODE_STOPPED;
    end
    if (item_i.start_button && (nxt_o.mode == MODE_STOPPED)) begin
      nxt_o.motor = 1'b1;
      nxt_o.mode  = MODE_ADVANCING;
    end

    case (nxt_o.mode)
      MODE_ADVANCING: begin
        if (!item_i.beam_clear) begin
          nxt_o.motor       = 1'b0;
          nxt_o.dwell       = '0;
          nxt_o.mode        = MODE_ANALYSING;
          nxt_o.lamp_red    = 1'b0;
          nxt_o.lamp_green  = 1'b0;
          nxt_o.lamp_blue   = 1'b0;
          nxt_o.blue_angle  = '0;
          nxt_o.green_angle = '0;
          nxt_o.cls         = CLASS_NONE;
          if (pick_blue) begin
            nxt_o.lamp_blue  = 1'b1;
            nxt_o.blue_angle = angle_sat;
            nxt_o.cls        = CLASS_BLUE;
          end else if (pick_green) begin
            nxt_o.lamp_green  = 1'b1;
            nxt_o.green_angle = angle_sat;
            nxt_o.cls         = CLASS_GREEN;
          end else if (pick_red) begin
            nxt_o.lamp_red = 1'b1;
            nxt_o.cls      = CLASS_RED;
          end
        end
      end
      MODE_ANALYSING: begin
        dwell_inc = (nxt_o.dwell < limit) ? nxt_o.dwell + TicksW'(1) : nxt_o.dwell;
        if (dwell_inc >= limit) begin
          nxt_o.dwell      = '0;
          nxt_o.lamp_red   = 1'b0;
          nxt_o.lamp_green = 1'b0;
          nxt_o.lamp_blue  = 1'b0;
          nxt_o.motor      = 1'b1;
          nxt_o.mode       = MODE_WAITING;
        end else begin
          nxt_o.dwell = dwell_inc;
        end
      end
      MODE_WAITING: begin
        if (item_i.beam_clear) begin
          nxt_o.mode = MODE_ADVANCING;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> tb/conveyor_color_sorter_controller_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conveyor_color_sorter_controller_top_tb
// Self-checking bench for the colour sorter controller. Tick beats are
// driven on the input channel and every result beat is compared field by
// field against a cycle-free model of the phase sequencer, the colour
// decision and the drive state. A short table of directed ticks runs first.
// Random tick streams follow under several register settings and idle mixes.
// ---------------------------------------------------------------------------
module conveyor_color_sorter_controller_top_tb;
  import ccs_pkg::*;

  // Idle mixes applied per phase of the run
  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  // One result beat, in the order the ports list it
  typedef struct packed {
    mode_e             phase;
    logic              motor_run;
    logic              lamp_red;
    logic              lamp_green;
    logic              lamp_blue;
    logic [AngleW-1:0] blue_angle;
    logic [AngleW-1:0] green_angle;
    class_e            cls;
  } tick_result_t;

  // Directed row: a tick, and a hand-written result where one is obvious
  typedef struct packed {
    item_t        stim;
    logic         typed;
    tick_result_t want;
  } dir_row_t;

  typedef struct packed {
    logic [TicksW-1:0]  ticks;
    logic [MarginW-1:0] margin;
    logic [AngleW-1:0]  angle;
    int unsigned        items;
    idle_e              idle;
  } phase_plan_t;

  localparam int unsigned GapPct      = 53;
  localparam int unsigned BothGapPct  = 25;
  localparam int unsigned LongHoldCyc = 60;
  localparam int unsigned MaxPrinted  = 100;
  localparam int unsigned TailCycles  = 20;

  // Lamp bits: red, green, blue from msb down
  localparam logic [2:0] LampOff   = 3'b000;
  localparam logic [2:0] LampRed   = 3'b100;
  localparam logic [2:0] LampGreen = 3'b010;
  localparam logic [2:0] LampBlue  = 3'b001;

  localparam logic [WidthW-1:0] WMax = '1;

  localparam item_t Restart = '{1'b1, 1'b1, 1'b1, '0, '0, '0};

  localparam tick_result_t AllOff =
    '{MODE_STOPPED, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, CLASS_NONE};
  localparam tick_result_t Running =
    '{MODE_ADVANCING, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, CLASS_NONE};
  localparam tick_result_t BlueHeld =
    '{MODE_ANALYSING, 1'b0, 1'b0, 1'b0, 1'b1, AngleRst, '0, CLASS_BLUE};

  // Directed ticks, run with the reset values of the registers
  // (dwell of two million ticks, so analysis never ends here)
  localparam int unsigned NumDirRows = 21;
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{'{1'b0, 1'b0, 1'b1, '0, '0, '0}, 1'b1, AllOff},       // idle after reset
    '{'{1'b0, 1'b1, 1'b1, '0, '0, '0}, 1'b1, AllOff},       // stop while stopped
    '{'{1'b1, 1'b0, 1'b1, '0, '0, '0}, 1'b1, Running},      // start, beam clear
    '{'{1'b1, 1'b0, 1'b1, '0, '0, '0}, 1'b1, Running},      // start ignored
    '{'{1'b0, 1'b0, 1'b0, 17'd1000, 17'd1000, 17'd100}, 1'b1, BlueHeld},
    '{'{1'b1, 1'b0, 1'b0, 17'd1000, 17'd1000, 17'd100}, 1'b1, BlueHeld},
    // stop while analysing keeps the class only
    '{'{1'b0, 1'b1, 1'b0, '0, '0, '0}, 1'b1,
      '{MODE_STOPPED, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, CLASS_BLUE}},
    // stop and start together while stopped
    '{Restart, 1'b1, '{MODE_ADVANCING, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, CLASS_BLUE}},
    '{Restart, 1'b0, '0},                                   // stop+start running
    '{'{1'b0, 1'b0, 1'b0, WMax, WMax, WMax}, 1'b1,          // three-way tie at top
      '{MODE_ANALYSING, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, CLASS_NONE}},
    '{Restart, 1'b0, '0},
    '{'{1'b0, 1'b0, 1'b0, WMax, '0, WMax}, 1'b0, '0},      // green, extremes
    '{Restart, 1'b0, '0},
    '{'{1'b0, 1'b0, 1'b0, 17'd5, 17'd21, 17'd21}, 1'b0, '0}, // red, lead one past
    '{Restart, 1'b0, '0},
    '{'{1'b0, 1'b0, 1'b0, 17'd100, 17'd115, 17'd115}, 1'b0, '0}, // lead equals margin
    '{Restart, 1'b0, '0},
    '{'{1'b0, 1'b0, 1'b0, '0, '0, '0}, 1'b0, '0},          // all timed out
    // restart with the object still in the beam: decided in the same tick
    '{'{1'b1, 1'b1, 1'b0, 17'd100, 17'd1000, 17'd1000}, 1'b0, '0},
    '{'{1'b0, 1'b1, 1'b1, '0, '0, '0}, 1'b0, '0},
    '{'{1'b0, 1'b0, 1'b1, WMax, WMax, WMax}, 1'b0, '0}
  };

  // Register settings per phase; dwell extremes and angle saturation included
  localparam int unsigned ExtremePhase  = 3;
  localparam int unsigned PressurePhase = 4;
  localparam phase_plan_t Plan [7] = '{
    '{26'd3,        16'd15,    8'd45,  170, IDLE_NONE},
    '{26'd1,        16'd0,     8'd180, 170, IDLE_SEND},
    '{26'd0,        16'd65535, 8'd255, 150, IDLE_RECV},
    '{26'h3FF_FFFF, 16'd200,   8'd181, 40,  IDLE_BOTH},
    '{26'd2,        16'd200,   8'd181, 150, IDLE_NONE},
    '{26'd7,        16'd40,    8'd90,  150, IDLE_BOTH},
    '{26'd4,        16'd1000,  8'd0,   120, IDLE_RECV}
  };

  logic clk_i;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  ccs_in_if  tick_if ();
  ccs_out_if drive_if ();

  conveyor_color_sorter_controller_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (tick_if),
    .out_if      (drive_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Model copy of the registers
  logic [TicksW-1:0]  reg_ticks;
  logic [MarginW-1:0] reg_margin;
  logic [AngleW-1:0]  reg_angle;

  // Model copy of the controller state
  mode_e             belt_mode;
  int unsigned       dwell_ticks;
  logic              belt_motor;
  logic [2:0]        lamp_rgb;
  logic [AngleW-1:0] blue_ang;
  logic [AngleW-1:0] green_ang;
  class_e            decided_class;

  tick_result_t awaited_states [$];   // expected result beats, oldest first
  int unsigned  n_errors;
  int unsigned  beats_seen;
  int unsigned  send_gap_pct;
  int unsigned  recv_stall_pct;
  bit           long_hold_req;
  int unsigned  obj_left;             // ticks the current object stays in the beam

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #2_000_000;
    $display("conveyor_color_sorter_controller_top_tb: done, errors");
    $finish;
  end

  task automatic report_error(input string msg);
    n_errors++;
    // keep a broken block from flooding the log
    if (n_errors <= MaxPrinted) $display("%0t ns  ERROR  %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_error($sformatf("beat %0d %s: got %0d, expected %0d",
                             beats_seen, name, got, want));
  endtask

  // One tick of the controller: stop first, then start, then the phase step
  function automatic tick_result_t step_sorter(input item_t it);
    int unsigned       limit;
    int unsigned       r;
    int unsigned       g;
    int unsigned       b;
    int unsigned       m;
    logic [AngleW-1:0] push;
    tick_result_t      res;
    limit = (reg_ticks == '0) ? 32'd1 : 32'(reg_ticks);   // zero dwell acts as one
    r     = 32'(it.red_width);
    g     = 32'(it.green_width);
    b     = 32'(it.blue_width);
    m     = 32'(reg_margin);
    push  = (reg_angle > AngleMax) ? AngleMax : reg_angle;
    if (it.stop_button && belt_mode != MODE_STOPPED) begin
      belt_motor  = 1'b0;
      lamp_rgb    = LampOff;
      blue_ang    = '0;
      green_ang   = '0;
      dwell_ticks = 0;
      belt_mode   = MODE_STOPPED;
    end
    if (it.start_button && belt_mode == MODE_STOPPED) begin
      belt_motor = 1'b1;
      belt_mode  = MODE_ADVANCING;
    end
    case (belt_mode)
      MODE_ADVANCING: begin
        if (!it.beam_clear) begin
          belt_motor    = 1'b0;
          dwell_ticks   = 0;
          belt_mode     = MODE_ANALYSING;
          lamp_rgb      = LampOff;
          blue_ang      = '0;
          green_ang     = '0;
          decided_class = CLASS_NONE;
          // sums, not differences: a margin above the width must not wrap
          if (b + m < r && b + m < g) begin
            lamp_rgb      = LampBlue;
            blue_ang      = push;
            decided_class = CLASS_BLUE;
          end else if (g + m < r && g + m < b) begin
            lamp_rgb      = LampGreen;
            green_ang     = push;
            decided_class = CLASS_GREEN;
          end else if (r + m < g && r + m < b) begin
            lamp_rgb      = LampRed;
            decided_class = CLASS_RED;
          end
        end
      end
      MODE_ANALYSING: begin
        if (dwell_ticks < limit) dwell_ticks++;
        if (dwell_ticks >= limit) begin
          dwell_ticks = 0;
          lamp_rgb    = LampOff;
          belt_motor  = 1'b1;
          belt_mode   = MODE_WAITING;
        end
      end
      MODE_WAITING: begin
        if (it.beam_clear) belt_mode = MODE_ADVANCING;
      end
      default: ;
    endcase
    res = '{belt_mode, belt_motor, lamp_rgb[2], lamp_rgb[1], lamp_rgb[0],
            blue_ang, green_ang, decided_class};
    return res;
  endfunction

  // Random tick: mostly objects passing on a running belt, with colour
  // leads placed around the margin; some full-range noise, ties and timeouts
  function automatic item_t random_tick();
    item_t       it;
    int          w [3];
    int          base;
    int          pick;
    int unsigned shape;
    it.start_button = (belt_mode == MODE_STOPPED) ? ($urandom_range(0, 99) < 60)
                                                  : ($urandom_range(0, 99) < 3);
    it.stop_button  = $urandom_range(0, 99) < 3;
    if (obj_left == 0 && $urandom_range(0, 99) < 25) obj_left = $urandom_range(1, 8);
    it.beam_clear = (obj_left == 0);
    if (obj_left != 0) obj_left--;
    shape = $urandom_range(0, 9);
    case (shape)
      0: foreach (w[i]) w[i] = $urandom_range(0, WMax);
      1: foreach (w[i]) w[i] = $urandom_range(0, 1) ? 0 : $urandom_range(0, WMax);
      2: begin
        base = $urandom_range(0, WMax);
        foreach (w[i]) w[i] = base;
      end
      default: begin
        base = $urandom_range(0, 60000);
        pick = $urandom_range(0, 2);
        foreach (w[i]) begin
          if (i == pick) begin
            w[i] = base;
          end else begin
            w[i] = base + int'(reg_margin) +
                   ($urandom_range(0, 1) ? int'($urandom_range(0, 3)) - 1
                                         : int'($urandom_range(0, 2000)));
            if (w[i] < 0) w[i] = 0;
          end
        end
      end
    endcase
    it.red_width   = WidthW'(w[0]);
    it.green_width = WidthW'(w[1]);
    it.blue_width  = WidthW'(w[2]);
    return it;
  endfunction

  // Offer one tick beat; the expectation is queued once the beat is taken
  task automatic send_tick(input item_t it, input logic typed, input tick_result_t want);
    tick_result_t model;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid        <= 1'b1;
    tick_if.start_button <= it.start_button;
    tick_if.stop_button  <= it.stop_button;
    tick_if.beam_clear   <= it.beam_clear;
    tick_if.red_width    <= it.red_width;
    tick_if.green_width  <= it.green_width;
    tick_if.blue_width   <= it.blue_width;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    model = step_sorter(it);
    awaited_states.push_back(typed ? want : model);
  endtask

  task automatic drain_results();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_states.size() != 0) @(posedge clk_i);
  endtask

  // All three registers, one per edge; block is idle when this runs
  task automatic load_settings(input phase_plan_t p);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ANALYSIS_TICKS;
    cfg_wdata_i <= CfgW'(p.ticks);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MARGIN;
    cfg_wdata_i <= CfgW'(p.margin);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_PUSH_ANGLE;
    cfg_wdata_i <= CfgW'(p.angle);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reg_ticks  = p.ticks;
    reg_margin = p.margin;
    reg_angle  = p.angle;
  endtask

  // Result side: check every taken beat, then pick next cycle's ready
  initial begin : result_sink
    tick_result_t want;
    int unsigned  hold_left;
    hold_left      = 0;
    drive_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (drive_if.valid && drive_if.ready) begin
        if (awaited_states.size() == 0) begin
          report_error($sformatf("beat %0d arrived with nothing expected", beats_seen));
        end else begin
          want = awaited_states.pop_front();
          check_field("phase",      8'(drive_if.phase),      8'(want.phase));
          check_field("motor_run",  8'(drive_if.motor_run),  8'(want.motor_run));
          check_field("lamp_red",   8'(drive_if.lamp_red),   8'(want.lamp_red));
          check_field("lamp_green", 8'(drive_if.lamp_green), 8'(want.lamp_green));
          check_field("lamp_blue",  8'(drive_if.lamp_blue),  8'(want.lamp_blue));
          check_field("blue_servo_angle",  drive_if.blue_servo_angle,  want.blue_angle);
          check_field("green_servo_angle", drive_if.green_servo_angle, want.green_angle);
          check_field("color_class", 8'(drive_if.color_class), 8'(want.cls));
        end
        beats_seen++;
      end
      // long hold-off: the input side backs up and ready drops
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LongHoldCyc;
      end
      if (hold_left != 0) begin
        hold_left--;
        drive_if.ready <= 1'b0;
      end else begin
        drive_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    item_t probe;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_ANALYSIS_TICKS;
    cfg_wdata_i          = '0;
    tick_if.valid        = 1'b0;
    tick_if.start_button = 1'b0;
    tick_if.stop_button  = 1'b0;
    tick_if.beam_clear   = 1'b1;
    tick_if.red_width    = '0;
    tick_if.green_width  = '0;
    tick_if.blue_width   = '0;
    n_errors       = 0;
    beats_seen     = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    long_hold_req  = 1'b0;
    obj_left       = 0;
    // model at reset
    reg_ticks     = TicksRst;
    reg_margin    = MarginRst;
    reg_angle     = AngleRst;
    belt_mode     = MODE_STOPPED;
    dwell_ticks   = 0;
    belt_motor    = 1'b0;
    lamp_rgb      = LampOff;
    blue_ang      = '0;
    green_ang     = '0;
    decided_class = CLASS_NONE;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks on reset registers, no idling
    foreach (DirRows[i]) send_tick(DirRows[i].stim, DirRows[i].typed, DirRows[i].want);
    drain_results();

    foreach (Plan[p]) begin
      load_settings(Plan[p]);
      send_gap_pct   = (Plan[p].idle == IDLE_SEND) ? GapPct :
                       (Plan[p].idle == IDLE_BOTH) ? BothGapPct : 0;
      recv_stall_pct = (Plan[p].idle == IDLE_RECV) ? GapPct :
                       (Plan[p].idle == IDLE_BOTH) ? BothGapPct : 0;
      for (int n = 0; n < Plan[p].items; n++) begin
        if (p == PressurePhase && n == 20) long_hold_req = 1'b1;
        // sender waits for every result before carrying on
        if (p == PressurePhase && n == 90) drain_results();
        send_tick(random_tick(), 1'b0, '0);
      end
      // park the belt mid-dwell under the longest dwell; the next phase
      // lowers the register below the count, which ends the dwell at once
      if (p == ExtremePhase) begin
        send_tick(Restart, 1'b0, '0);
        repeat (6) begin
          probe              = random_tick();
          probe.start_button = 1'b0;
          probe.stop_button  = 1'b0;
          probe.beam_clear   = 1'b0;
          send_tick(probe, 1'b0, '0);
        end
      end
      drain_results();
    end

    // keep the clock running to catch stray beats
    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("conveyor_color_sorter_controller_top_tb: done, clean");
    end else begin
      $display("conveyor_color_sorter_controller_top_tb: done, errors");
    end
    $finish;
  end

endmodule
